// ===== rtl/rarmt_pkg.sv =====
// Shared constants and types for the range-add range-minimum tree.
package rarmt_pkg;

    localparam int LEAVES = 1024;
    localparam int NODES = 2 * LEAVES;
    localparam int NODE_W = $clog2(NODES);
    localparam int POS_W = $clog2(LEAVES);
    localparam int DATA_W = 64;
    localparam int SIZE_W = POS_W + 1;
    localparam int STACK_DEPTH = $clog2(LEAVES) + 1;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [DATA_W-1:0] EMPTY_MIN = 64'd2000000000000000000;
    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_MIN   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

endpackage

// ===== rtl/rarmt_if.sv =====
// Request and response channel interfaces for the range-add range-minimum tree.
interface rarmt_req_if;
    import rarmt_pkg::*;

    logic                     valid;
    logic                     ready;
    action_t                  action;
    logic [POS_W-1:0]         range_left;
    logic [POS_W-1:0]         range_right;
    logic signed [DATA_W-1:0] addend;

    modport source (output valid, action, range_left, range_right, addend, input ready);
    modport sink (input valid, action, range_left, range_right, addend, output ready);
endinterface

interface rarmt_rsp_if;
    import rarmt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] min_value;
    logic                     empty_span;
    logic                     overflow_seen;

    modport source (output valid, min_value, empty_span, overflow_seen, input ready);
    modport sink (input valid, min_value, empty_span, overflow_seen, output ready);
endinterface

// ===== rtl/rarmt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rarmt_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/range_add_range_min_tree.sv =====
// Top level of the lazy segment tree with range add and range minimum.
//
//   channel   direction   handshake          payload
//   req       in          valid / ready      action, range_left, range_right, addend
//   rsp       out         valid / ready      min_value, empty_span, overflow_seen
//   cfg       in          cfg_we             cfg_wdata (size_in_use)
//
// After reset all 2048 entries of the node memories are swept to zero before req is ready.
// A clear transaction sweeps them again; empty spans and unused actions skip the tree walk.
// An add or query walks from the root: a fully covered node is updated or compared, a split
// node pushes its pending add into both children, and an add rebuilds split node minima on
// the way back. A new transaction is taken while a result waits on rsp.
module range_add_range_min_tree (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rarmt_pkg::SIZE_W-1:0] cfg_wdata,
    rarmt_req_if.sink                    req,
    rarmt_rsp_if.source                  rsp
);
    import rarmt_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_VISIT, S_LEAF, S_PUSH0, S_PUSH1, S_PUSH2, S_PUSH3,
        S_RET, S_POST0, S_POST1, S_POST2, S_CLEAR, S_DONE
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  tl;
        logic [POS_W-1:0]  tr;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic              went_right;
    } frame_t;

    state_t                   state_reg, state_next;
    logic [STACK_CNT_W-1:0]   sp_reg, sp_next;
    frame_t                   stack_reg [STACK_DEPTH];
    frame_t                   stack_next [STACK_DEPTH];
    logic                     wrap_reg, wrap_next;
    logic [SIZE_W-1:0]        size_reg, size_next;
    logic [NODE_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     op_add_reg, op_add_next;
    logic [DATA_W-1:0]        addend_reg, addend_next;
    logic [DATA_W-1:0]        p_reg, p_next;
    logic [DATA_W-1:0]        c0_reg, c0_next;
    logic [DATA_W-1:0]        best_reg, best_next;
    logic [DATA_W-1:0]        res_min_reg, res_min_next;
    logic                     res_empty_reg, res_empty_next;
    logic [DATA_W-1:0]        out_min_reg, out_min_next;
    logic                     out_empty_reg, out_empty_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic [STACK_CNT_W-1:0]   sp_m1;
    logic [STACK_IDX_W-1:0]   top_idx;
    logic [STACK_IDX_W-1:0]   push_idx;
    frame_t                   top;
    frame_t                   left_frame;
    frame_t                   right_frame;
    logic [POS_W:0]           mid_sum;
    logic [POS_W-1:0]         mid;
    logic                     exact;
    logic [SIZE_W-1:0]        n_eff;
    logic [POS_W-1:0]         n_last;
    logic                     span_bad;
    logic                     accept;

    logic [NODE_W-1:0]        rd_addr;
    logic                     mn_we, pd_we;
    logic [NODE_W-1:0]        mn_waddr, pd_waddr;
    logic [DATA_W-1:0]        mn_wdata, pd_wdata;
    logic [DATA_W-1:0]        mn_rdata, pd_rdata;
    logic [DATA_W-1:0]        add_src;
    logic [DATA_W-1:0]        mn_sum, pd_sum;
    logic                     mn_wrap, pd_wrap;

    rarmt_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_min_ram (
        .clk   (clk),
        .we    (mn_we),
        .waddr (mn_waddr),
        .wdata (mn_wdata),
        .raddr (rd_addr),
        .rdata (mn_rdata)
    );

    rarmt_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_pend_ram (
        .clk   (clk),
        .we    (pd_we),
        .waddr (pd_waddr),
        .wdata (pd_wdata),
        .raddr (rd_addr),
        .rdata (pd_rdata)
    );

    always_comb
    begin
        sp_m1    = sp_reg - 1'b1;
        top_idx  = sp_m1[STACK_IDX_W-1:0];
        push_idx = sp_reg[STACK_IDX_W-1:0];
        top      = stack_reg[top_idx];
        mid_sum  = {1'b0, top.tl} + {1'b0, top.tr};
        mid      = mid_sum[POS_W:1];
        exact    = (top.lo == top.tl) && (top.hi == top.tr);

        left_frame.node       = {top.node[NODE_W-2:0], 1'b0};
        left_frame.tl         = top.tl;
        left_frame.tr         = mid;
        left_frame.lo         = top.lo;
        left_frame.hi         = (top.hi < mid) ? top.hi : mid;
        left_frame.went_right = 1'b0;

        right_frame.node       = {top.node[NODE_W-2:0], 1'b1};
        right_frame.tl         = POS_W'(mid + 1'b1);
        right_frame.tr         = top.tr;
        right_frame.lo         = (top.lo > mid) ? top.lo : POS_W'(mid + 1'b1);
        right_frame.hi         = top.hi;
        right_frame.went_right = 1'b0;

        if (size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(LEAVES))
        begin
            n_eff = SIZE_W'(LEAVES);
        end
        else
        begin
            n_eff = size_reg;
        end
        n_last   = POS_W'(n_eff - 1'b1);
        span_bad = (req.range_left > req.range_right) || (req.range_right > n_last);

        add_src = (state_reg == S_LEAF) ? addend_reg : p_reg;
        mn_sum  = mn_rdata + add_src;
        pd_sum  = pd_rdata + add_src;
        mn_wrap = (mn_rdata[DATA_W-1] == add_src[DATA_W-1]) &&
                  (mn_sum[DATA_W-1] != add_src[DATA_W-1]);
        pd_wrap = (pd_rdata[DATA_W-1] == add_src[DATA_W-1]) &&
                  (pd_sum[DATA_W-1] != add_src[DATA_W-1]);
    end

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        stack_next     = stack_reg;
        wrap_next      = wrap_reg;
        size_next      = cfg_we ? cfg_wdata : size_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        op_add_next    = op_add_reg;
        addend_next    = addend_reg;
        p_next         = p_reg;
        c0_next        = c0_reg;
        best_next      = best_reg;
        res_min_next   = res_min_reg;
        res_empty_next = res_empty_reg;
        out_min_next   = out_min_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;

        rd_addr  = top.node;
        mn_we    = 1'b0;
        pd_we    = 1'b0;
        mn_waddr = top.node;
        pd_waddr = top.node;
        mn_wdata = mn_sum;
        pd_wdata = pd_sum;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mn_we        = 1'b1;
                pd_we        = 1'b1;
                mn_waddr     = clr_cnt_reg;
                pd_waddr     = clr_cnt_reg;
                mn_wdata     = '0;
                pd_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {NODE_W{1'b1}})
                begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_min_next   = '0;
                    res_empty_next = 1'b0;
                    case (req.action)
                        ACT_CLEAR:
                        begin
                            wrap_next    = 1'b0;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        ACT_ADD, ACT_MIN:
                        begin
                            if (span_bad)
                            begin
                                res_empty_next = 1'b1;
                                res_min_next   = (req.action == ACT_MIN) ? EMPTY_MIN : '0;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                stack_next[0].node       = NODE_W'(1);
                                stack_next[0].tl         = '0;
                                stack_next[0].tr         = n_last;
                                stack_next[0].lo         = req.range_left;
                                stack_next[0].hi         = req.range_right;
                                stack_next[0].went_right = 1'b0;
                                sp_next                  = STACK_CNT_W'(1);
                                op_add_next              = (req.action == ACT_ADD);
                                addend_next              = req.addend;
                                best_next                = MAX_POS;
                                state_next               = S_VISIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_VISIT:
            begin
                rd_addr    = top.node;
                state_next = exact ? S_LEAF : S_PUSH0;
            end
            S_LEAF:
            begin
                if (op_add_reg)
                begin
                    mn_we     = 1'b1;
                    pd_we     = 1'b1;
                    wrap_next = wrap_reg || mn_wrap || pd_wrap;
                end
                else if ($signed(mn_rdata) < $signed(best_reg))
                begin
                    best_next = mn_rdata;
                end
                sp_next    = sp_m1;
                state_next = S_RET;
            end
            S_PUSH0:
            begin
                p_next     = pd_rdata;
                rd_addr    = left_frame.node;
                state_next = S_PUSH1;
            end
            S_PUSH1:
            begin
                mn_we      = 1'b1;
                pd_we      = 1'b1;
                mn_waddr   = left_frame.node;
                pd_waddr   = left_frame.node;
                wrap_next  = wrap_reg || mn_wrap || pd_wrap;
                rd_addr    = right_frame.node;
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                mn_we      = 1'b1;
                pd_we      = 1'b1;
                mn_waddr   = right_frame.node;
                pd_waddr   = right_frame.node;
                wrap_next  = wrap_reg || mn_wrap || pd_wrap;
                state_next = S_PUSH3;
            end
            S_PUSH3:
            begin
                pd_we    = 1'b1;
                pd_waddr = top.node;
                pd_wdata = '0;
                if (top.lo <= mid)
                begin
                    stack_next[push_idx] = left_frame;
                end
                else
                begin
                    stack_next[top_idx].went_right = 1'b1;
                    stack_next[push_idx]           = right_frame;
                end
                sp_next    = sp_reg + 1'b1;
                state_next = S_VISIT;
            end
            S_RET:
            begin
                if (sp_reg == '0)
                begin
                    res_min_next   = op_add_reg ? '0 : best_reg;
                    res_empty_next = 1'b0;
                    state_next     = S_DONE;
                end
                else if (!top.went_right && (top.hi > mid))
                begin
                    stack_next[top_idx].went_right = 1'b1;
                    stack_next[push_idx]           = right_frame;
                    sp_next                        = sp_reg + 1'b1;
                    state_next                     = S_VISIT;
                end
                else if (op_add_reg)
                begin
                    state_next = S_POST0;
                end
                else
                begin
                    sp_next = sp_m1;
                end
            end
            S_POST0:
            begin
                rd_addr    = left_frame.node;
                state_next = S_POST1;
            end
            S_POST1:
            begin
                c0_next    = mn_rdata;
                rd_addr    = right_frame.node;
                state_next = S_POST2;
            end
            S_POST2:
            begin
                mn_we      = 1'b1;
                mn_waddr   = top.node;
                mn_wdata   = ($signed(c0_reg) < $signed(mn_rdata)) ? c0_reg : mn_rdata;
                sp_next    = sp_m1;
                state_next = S_RET;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_min_next   = res_min_reg;
                    out_empty_next = res_empty_reg;
                    out_ovf_next   = wrap_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sp_reg        <= '0;
            wrap_reg      <= 1'b0;
            size_reg      <= SIZE_W'(LEAVES);
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            wrap_reg      <= wrap_next;
            size_reg      <= size_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg     <= stack_next;
        op_add_reg    <= op_add_next;
        addend_reg    <= addend_next;
        p_reg         <= p_next;
        c0_reg        <= c0_next;
        best_reg      <= best_next;
        res_min_reg   <= res_min_next;
        res_empty_reg <= res_empty_next;
        out_min_reg   <= out_min_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.min_value     = out_min_reg;
    assign rsp.empty_span    = out_empty_reg;
    assign rsp.overflow_seen = out_ovf_reg;

endmodule

// ===== tb/range_add_range_min_tree_checker.sv =====
// Checker that predicts and compares every result of the range-add range-minimum tree.
`timescale 1ns / 100ps

module range_add_range_min_tree_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rarmt_pkg::SIZE_W-1:0] cfg_wdata,
    rarmt_req_if                         req,
    rarmt_rsp_if                         rsp,
    output int                           mismatches,
    output int                           outstanding
);
    import rarmt_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] min_value;
        logic              empty_span;
        logic              overflow_seen;
    } tree_answer_t;

    localparam int TREE_SLOTS = 4 * LEAVES;

    logic [DATA_W-1:0] node_low[TREE_SLOTS];
    logic [DATA_W-1:0] node_lazy[TREE_SLOTS];
    bit                wrapped;
    logic [SIZE_W-1:0] size_reg;
    tree_answer_t      answers_due[$];

    function automatic void wipe_tree();
        for (int i = 0; i < TREE_SLOTS; i++)
        begin
            node_low[i] = '0;
            node_lazy[i] = '0;
        end
        wrapped = 0;
    endfunction

    function automatic logic [DATA_W-1:0] sum_wrap(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] s;
        s = a + b;
        if (((a ^ s) & (b ^ s)) >> (DATA_W - 1))
            wrapped = 1;
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] lower_of(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic void push_lazy(input int unsigned v);
        logic [DATA_W-1:0] p;
        p = node_lazy[v];
        for (int unsigned c = 2 * v; c <= 2 * v + 1; c++)
        begin
            if (c >= TREE_SLOTS)
                break;
            node_low[c] = sum_wrap(node_low[c], p);
            node_lazy[c] = sum_wrap(node_lazy[c], p);
        end
        node_lazy[v] = '0;
    endfunction

    function automatic void add_span(input int unsigned v, input int unsigned lo,
                                     input int unsigned hi, input int unsigned l,
                                     input int unsigned r, input logic [DATA_W-1:0] a);
        int unsigned mid;
        if (v >= TREE_SLOTS)
            return;
        if (l == lo && r == hi)
        begin
            node_low[v] = sum_wrap(node_low[v], a);
            node_lazy[v] = sum_wrap(node_lazy[v], a);
            return;
        end
        if (2 * v + 1 >= TREE_SLOTS)
            return;
        push_lazy(v);
        mid = (lo + hi) / 2;
        if (l <= mid)
            add_span(2 * v, lo, mid, l, (r < mid) ? r : mid, a);
        if (r > mid)
            add_span(2 * v + 1, mid + 1, hi, (l > mid + 1) ? l : mid + 1, r, a);
        node_low[v] = lower_of(node_low[2 * v], node_low[2 * v + 1]);
    endfunction

    function automatic logic [DATA_W-1:0] span_low(input int unsigned v,
                                                   input int unsigned lo,
                                                   input int unsigned hi,
                                                   input int unsigned l,
                                                   input int unsigned r);
        int unsigned       mid;
        logic [DATA_W-1:0] best;
        logic [DATA_W-1:0] right_low;
        bit                have;
        best = '0;
        have = 0;
        if (v >= TREE_SLOTS)
            return EMPTY_MIN;
        if ((l == lo && r == hi) || 2 * v + 1 >= TREE_SLOTS)
            return node_low[v];
        push_lazy(v);
        mid = (lo + hi) / 2;
        if (l <= mid)
        begin
            best = span_low(2 * v, lo, mid, l, (r < mid) ? r : mid);
            have = 1;
        end
        if (r > mid)
        begin
            right_low = span_low(2 * v + 1, mid + 1, hi, (l > mid + 1) ? l : mid + 1, r);
            best = have ? lower_of(best, right_low) : right_low;
        end
        return best;
    endfunction

    function automatic tree_answer_t work_out(input action_t act, input int unsigned l,
                                              input int unsigned r,
                                              input logic [DATA_W-1:0] a);
        tree_answer_t res;
        int unsigned  n;
        res = '0;
        n = size_reg;
        if (n == 0)
            n = 1;
        if (n > LEAVES)
            n = LEAVES;
        if (act == ACT_CLEAR)
            wipe_tree();
        else if (act == ACT_ADD || act == ACT_MIN)
        begin
            if (l > r || r >= n)
            begin
                res.empty_span = 1'b1;
                if (act == ACT_MIN)
                    res.min_value = EMPTY_MIN;
            end
            else if (act == ACT_ADD)
                add_span(1, 0, n - 1, l, r, a);
            else
                res.min_value = span_low(1, 0, n - 1, l, r);
        end
        res.overflow_seen = wrapped;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tree_answer_t due;
        tree_answer_t fresh;
        if (!rst_n)
        begin
            wipe_tree();
            size_reg = SIZE_W'(LEAVES);
            answers_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                size_reg = cfg_wdata;
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result transaction arrived with nothing expected");
                    mismatches++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (rsp.min_value !== due.min_value)
                    begin
                        $error("min_value: expected %0d, got %0d",
                               $signed(due.min_value), $signed(rsp.min_value));
                        mismatches++;
                    end
                    if (rsp.empty_span !== due.empty_span)
                    begin
                        $error("empty_span: expected %0b, got %0b",
                               due.empty_span, rsp.empty_span);
                        mismatches++;
                    end
                    if (rsp.overflow_seen !== due.overflow_seen)
                    begin
                        $error("overflow_seen: expected %0b, got %0b",
                               due.overflow_seen, rsp.overflow_seen);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                fresh = work_out(req.action, req.range_left, req.range_right, req.addend);
                answers_due = {answers_due, fresh};
            end
        end
        outstanding = answers_due.size();
    end

endmodule

// ===== tb/range_add_range_min_tree_tb.sv =====
// Top of the testbench: stimulus, stalls, size settings and the verdict for the tree.
`timescale 1ns / 100ps

module range_add_range_min_tree_tb;
    import rarmt_pkg::*;

    localparam int STALL_LIMIT = 30000;
    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    int                mismatches;
    int                outstanding;
    bit                calm;
    int                idle_cycles;
    int                kind_count[4];
    int                settings_used;
    int unsigned       leaves_now;

    rarmt_req_if req_ch ();
    rarmt_rsp_if rsp_ch ();

    range_add_range_min_tree u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    range_add_range_min_tree_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic send(input action_t act, input int unsigned l, input int unsigned r,
                        input logic [DATA_W-1:0] a);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_ch.action = act;
        req_ch.range_left = POS_W'(l);
        req_ch.range_right = POS_W'(r);
        req_ch.addend = a;
        req_ch.valid = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        kind_count[act]++;
        @(negedge clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] value);
        req_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        leaves_now = (value == 0) ? 1 : (value > LEAVES) ? LEAVES : value;
        settings_used++;
    endtask

    task automatic send_random();
        int unsigned       pick;
        int unsigned       l;
        int unsigned       r;
        int unsigned       t;
        logic [DATA_W-1:0] a;
        action_t           act;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            act = ACT_CLEAR;
        else if (pick < 4)
            act = ACT_NONE;
        else if (pick < 52)
            act = ACT_ADD;
        else
            act = ACT_MIN;
        l = $urandom_range(0, leaves_now - 1);
        r = $urandom_range(0, leaves_now - 1);
        if (l > r)
        begin
            t = l;
            l = r;
            r = t;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4 && leaves_now < LEAVES)
            r = $urandom_range(leaves_now, LEAVES - 1);
        else if (pick < 8)
        begin
            l = $urandom_range(1, LEAVES - 1);
            r = $urandom_range(0, l - 1);
        end
        else if (pick < 14)
            r = l;
        else if (pick < 18)
        begin
            l = 0;
            r = leaves_now - 1;
        end
        else if (pick < 22)
        begin
            l = $urandom_range(0, LEAVES - 1);
            r = $urandom_range(0, LEAVES - 1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
            a = DATA_W'($signed($urandom_range(0, 2000)) - 1000);
        else if (pick < 85)
            a = {$urandom, $urandom};
        else if (pick < 92)
            a = MAX_POS - DATA_W'($urandom_range(0, 3));
        else
            a = MOST_NEG + DATA_W'($urandom_range(0, 3));
        send(act, l, r, a);
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ch.ready = 1'b1;
            if (calm)
                @(negedge clk);
            else
            begin
                repeat ($urandom_range(1, 30)) @(negedge clk);
                if ($urandom_range(0, 2) == 0)
                begin
                    rsp_ch.ready = 1'b0;
                    repeat ($urandom_range(1, 18)) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        calm = 0;
        settings_used = 1;
        leaves_now = LEAVES;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_NONE;
        req_ch.range_left = '0;
        req_ch.range_right = '0;
        req_ch.addend = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(ACT_MIN, 0, LEAVES - 1, '0);
        send(ACT_ADD, 0, LEAVES - 1, 64'd5);
        send(ACT_ADD, 0, 0, MOST_NEG);
        send(ACT_MIN, 0, 1, '0);
        send(ACT_MIN, 5, 3, '0);
        send(ACT_ADD, 9, 2, 64'd77);
        send(ACT_ADD, LEAVES - 1, LEAVES - 1, MAX_POS);
        send(ACT_MIN, 1000, LEAVES - 1, '0);
        send(ACT_ADD, LEAVES - 1, LEAVES - 1, MAX_POS);
        send(ACT_MIN, LEAVES - 1, LEAVES - 1, '0);
        send(ACT_NONE, LEAVES - 1, LEAVES - 1, '1);
        send(ACT_CLEAR, 0, 0, '0);
        send(ACT_MIN, 0, LEAVES - 1, '0);
        send(ACT_ADD, 3, 700, -64'sd7);
        send(ACT_MIN, 2, 3, '0);
        send(ACT_MIN, 701, LEAVES - 1, '0);
        send(ACT_ADD, 511, 512, 64'd1);
        send(ACT_MIN, 512, 1023, '0);
        repeat (380) send_random();

        set_size(11'd1);
        send(ACT_MIN, 0, 1, '0);
        repeat (80) send_random();
        set_size(11'd0);
        repeat (40) send_random();
        set_size(11'd13);
        send(ACT_ADD, 5, 20, 64'd3);
        send(ACT_MIN, 0, 12, '0);
        repeat (200) send_random();
        set_size(11'd2047);
        repeat (300) send_random();
        set_size(11'd600);
        repeat (200) send_random();
        set_size(11'd1024);
        repeat (40) send_random();
        calm = 1;
        repeat (150) send_random();

        req_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        $display("Covered %0d adds, %0d queries, %0d clears and %0d unused actions",
                 kind_count[ACT_ADD], kind_count[ACT_MIN], kind_count[ACT_CLEAR],
                 kind_count[ACT_NONE]);
        $display("across %0d tree size settings, including zero and the largest code.",
                 settings_used);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
